[rtl/flash_sector_writeback_cache_assert.svh]
// Assertion macros used by the flash sector cache datapath (fswc_dp).
// Each macro expects clk and rst to be visible where it is used.
`ifndef FLASH_SECTOR_WRITEBACK_CACHE_ASSERT_SVH
`define FLASH_SECTOR_WRITEBACK_CACHE_ASSERT_SVH

// Same-cycle implication.
`define FSWC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FSWC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fswc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fswc_pkg
// Types, codes and constants of the flash sector write-back cache.
// ----------------------------------------------------------------------------
package fswc_pkg;

  localparam int SMALL_SECTOR_BYTES  = 8192;
  localparam int LARGE_SECTOR_BYTES  = 65536;
  localparam int MAX_REQUEST_SECTORS = 128;
  localparam int BLOCK_BYTES         = 512;
  localparam int NUM_PARTS           = 10;
  localparam int MAX_RESULTS         = 8;

  localparam int OFF_W   = 20;
  localparam int BYTES_W = 17;
  localparam int IDX_W   = 16;
  localparam int CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam logic [BYTES_W-1:0] SMALL_SIZE    = BYTES_W'(SMALL_SECTOR_BYTES);
  localparam logic [BYTES_W-1:0] LARGE_SIZE    = BYTES_W'(LARGE_SECTOR_BYTES);
  localparam logic [BYTES_W-1:0] MAX_REQ_BYTES =
    BYTES_W'(MAX_REQUEST_SECTORS * BLOCK_BYTES);
  localparam logic [3:0]         PART_LIMIT    = 4'(NUM_PARTS);
  localparam logic [CNT_W-1:0]   RES_LIMIT     = CNT_W'(MAX_RESULTS);
  localparam logic [CNT_W-1:0]   RES_LAST      = CNT_W'(MAX_RESULTS - 1);

  // Operation codes.
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [1:0] OP_BAD   = 2'd3;

  // Action codes.
  localparam logic [2:0] ACT_REJECT    = 3'd0;
  localparam logic [2:0] ACT_NOTHING   = 3'd1;
  localparam logic [2:0] ACT_RD_CACHE  = 3'd2;
  localparam logic [2:0] ACT_RD_FLASH  = 3'd3;
  localparam logic [2:0] ACT_WRITEBACK = 3'd4;
  localparam logic [2:0] ACT_LOAD      = 3'd5;
  localparam logic [2:0] ACT_WR_CACHE  = 3'd6;

  // Partition lengths in bytes; partitions are laid out back to back.
  function automatic logic [OFF_W-1:0] part_len(input logic [3:0] p);
    logic [OFF_W-1:0] r;
    case (p)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7: r = 20'h02000;
      4'd8:    r = 20'ha0000;
      4'd9:    r = 20'h50000;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Partitions 8 and 9 begin at or above byte 0x10000 and use large sectors.
  function automatic logic part_is_large(input logic [3:0] p);
    logic r;
    case (p)
      4'd8, 4'd9: r = 1'b1;
      default:    r = 1'b0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic       take;
    logic       chunk;
    logic       emit;
    logic [2:0] act;
    logic       final_res;
    logic       advance;
    logic       load;
    logic       mark_dirty;
    logic       mark_clean;
  } fswc_cmd_t;

  typedef struct packed {
    logic       accept;
    logic [1:0] op;
    logic       reject;
    logic       empty;
    logic       dirty_loaded;
    logic       held;
    logic       last_chunk;
    logic       emit_ok;
  } fswc_sts_t;

endpackage

[rtl/fswc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fswc_req_if / fswc_rsp_if
// Valid/ready channels for block requests and cache action results.
// ----------------------------------------------------------------------------
interface fswc_req_if;
  import fswc_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  partition;
  logic [10:0] start_sector;
  logic [7:0]  sector_count;

  modport source (output valid, operation, partition, start_sector, sector_count,
                  input ready);
  modport sink (input valid, operation, partition, start_sector, sector_count,
                output ready);
endinterface

interface fswc_rsp_if;
  import fswc_pkg::*;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [3:0]         target_partition;
  logic [OFF_W-1:0]   byte_offset;
  logic [BYTES_W-1:0] chunk_bytes;
  logic [IDX_W-1:0]   cache_index;
  logic               last;

  modport source (output valid, action, target_partition, byte_offset, chunk_bytes,
                  cache_index, last, input ready);
  modport sink (input valid, action, target_partition, byte_offset, chunk_bytes,
                cache_index, last, output ready);
endinterface

[rtl/fswc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fswc_ctrl
// Sequencer that walks each request through its checks and chunk actions.
// ----------------------------------------------------------------------------
module fswc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  fswc_pkg::fswc_sts_t sts,
  output fswc_pkg::fswc_cmd_t cmd
);
  import fswc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_CHUNK = 3'd2;
  localparam logic [2:0] S_ACT   = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;
  localparam logic [2:0] S_WRC   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.act    = ACT_NOTHING;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (sts.accept) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.final_res = 1'b1;
        cmd.emit      = sts.emit_ok;
        if (sts.op == OP_FLUSH) begin
          if (sts.dirty_loaded) begin
            cmd.act        = ACT_WRITEBACK;
            cmd.mark_clean = sts.emit_ok;
          end else begin
            cmd.act = ACT_NOTHING;
          end
          if (sts.emit_ok) begin
            state_next = S_IDLE;
          end
        end else if (sts.reject) begin
          cmd.act = ACT_REJECT;
          if (sts.emit_ok) begin
            state_next = S_IDLE;
          end
        end else if (sts.empty) begin
          cmd.act = ACT_NOTHING;
          if (sts.emit_ok) begin
            state_next = S_IDLE;
          end
        end else begin
          cmd.emit      = 1'b0;
          cmd.final_res = 1'b0;
          state_next    = S_CHUNK;
        end
      end
      S_CHUNK: begin
        cmd.chunk  = 1'b1;
        state_next = S_ACT;
      end
      S_ACT: begin
        if (sts.op == OP_READ) begin
          cmd.act       = sts.held && sts.dirty_loaded ? ACT_RD_CACHE : ACT_RD_FLASH;
          cmd.final_res = sts.last_chunk;
          cmd.emit      = sts.emit_ok;
          cmd.advance   = sts.emit_ok;
          if (sts.emit_ok) begin
            state_next = sts.last_chunk ? S_IDLE : S_CHUNK;
          end
        end else begin
          state_next = sts.held ? S_WRC : S_WB;
        end
      end
      S_WB: begin
        if (sts.dirty_loaded) begin
          cmd.act        = ACT_WRITEBACK;
          cmd.emit       = sts.emit_ok;
          cmd.mark_clean = sts.emit_ok;
          if (sts.emit_ok) begin
            state_next = S_LOAD;
          end
        end else begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.act  = ACT_LOAD;
        cmd.emit = sts.emit_ok;
        cmd.load = sts.emit_ok;
        if (sts.emit_ok) begin
          state_next = S_WRC;
        end
      end
      S_WRC: begin
        cmd.act        = ACT_WR_CACHE;
        cmd.final_res  = sts.last_chunk;
        cmd.emit       = sts.emit_ok;
        cmd.advance    = sts.emit_ok;
        cmd.mark_dirty = sts.emit_ok;
        if (sts.emit_ok) begin
          state_next = sts.last_chunk ? S_IDLE : S_CHUNK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/fswc_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fswc_dp
// Request registers, cache entry tags, chunk arithmetic and result register.
// ----------------------------------------------------------------------------
`include "flash_sector_writeback_cache_assert.svh"

module fswc_dp (
  input  logic                clk,
  input  logic                rst,
  fswc_req_if.sink            req,
  fswc_rsp_if.source          rsp,
  input  fswc_pkg::fswc_cmd_t cmd,
  output fswc_pkg::fswc_sts_t sts
);
  import fswc_pkg::*;

  // Request being worked on.
  logic [1:0]         op;
  logic [3:0]         part;
  logic [OFF_W-1:0]   off;
  logic [BYTES_W-1:0] len;
  logic               big_sec;

  // Cache entry.
  logic               loaded;
  logic               dirty;
  logic [3:0]         cpart;
  logic [OFF_W-1:0]   cstart;
  logic               clarge;

  // Current chunk.
  logic [BYTES_W-1:0] size;
  logic               held;
  logic [CNT_W-1:0]   cnt;

  logic               o_valid;
  logic [2:0]         o_action;
  logic [3:0]         o_part;
  logic [OFF_W-1:0]   o_off;
  logic [BYTES_W-1:0] o_bytes;
  logic [IDX_W-1:0]   o_idx;
  logic               o_last;

  logic [BYTES_W-1:0] ssize;
  logic [BYTES_W-1:0] smask;
  logic [BYTES_W-1:0] room;
  logic [BYTES_W-1:0] size_c;
  logic [BYTES_W-1:0] cbytes;
  logic [OFF_W:0]     chunk_end;
  logic [OFF_W:0]     cache_end;
  logic [OFF_W:0]     req_end;
  logic               held_c;
  logic               reject_c;
  logic [OFF_W-1:0]   aligned;
  logic [OFF_W-1:0]   rel;
  logic               accept;
  logic               do_out;

  logic [2:0]         f_action;
  logic [3:0]         f_part;
  logic [OFF_W-1:0]   f_off;
  logic [BYTES_W-1:0] f_bytes;
  logic [IDX_W-1:0]   f_idx;

  assign accept = req.valid && req.ready;
  assign do_out = cmd.emit && (cnt < RES_LIMIT);

  always_comb begin
    ssize     = big_sec ? LARGE_SIZE : SMALL_SIZE;
    smask     = ssize - BYTES_W'(1);
    room      = ssize - (off[BYTES_W-1:0] & smask);
    size_c    = (room > len) ? len : room;
    cbytes    = clarge ? LARGE_SIZE : SMALL_SIZE;
    chunk_end = {1'b0, off} + (OFF_W + 1)'(size_c);
    cache_end = {1'b0, cstart} + (OFF_W + 1)'(cbytes);
    held_c    = loaded && (cpart == part) && (off >= cstart) && (chunk_end <= cache_end);
    req_end   = {1'b0, off} + (OFF_W + 1)'(len);
    reject_c  = (op == OP_BAD) || (part >= PART_LIMIT) || (len > MAX_REQ_BYTES) ||
                (req_end > {1'b0, part_len(part)});
    aligned   = off & ~(OFF_W'(smask));
    rel       = off - cstart;
  end

  always_comb begin
    f_action = cmd.act;
    f_part   = '0;
    f_off    = '0;
    f_bytes  = '0;
    f_idx    = '0;
    case (cmd.act)
      ACT_RD_CACHE, ACT_WR_CACHE: begin
        f_part  = part;
        f_off   = off;
        f_bytes = size;
        f_idx   = rel[IDX_W-1:0];
      end
      ACT_RD_FLASH: begin
        f_part  = part;
        f_off   = off;
        f_bytes = size;
      end
      ACT_WRITEBACK: begin
        f_part  = cpart;
        f_off   = cstart;
        f_bytes = cbytes;
      end
      ACT_LOAD: begin
        f_part  = part;
        f_off   = aligned;
        f_bytes = ssize;
      end
      default: begin
        f_action = cmd.act;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= req.operation;
      part    <= req.partition;
      off     <= {req.start_sector, 9'b0};
      len     <= {req.sector_count, 9'b0};
      big_sec <= part_is_large(req.partition);
    end else if (cmd.advance) begin
      off <= off + OFF_W'(size);
      len <= len - size;
    end
    if (cmd.chunk) begin
      size <= size_c;
      held <= held_c;
    end
    if (do_out) begin
      o_action <= f_action;
      o_part   <= f_part;
      o_off    <= f_off;
      o_bytes  <= f_bytes;
      o_idx    <= f_idx;
      o_last   <= cmd.final_res || (cnt == RES_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded  <= 1'b0;
      dirty   <= 1'b0;
      cpart   <= '0;
      cstart  <= '0;
      clarge  <= 1'b0;
      cnt     <= '0;
      o_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        loaded <= 1'b1;
        cpart  <= part;
        cstart <= aligned;
        clarge <= big_sec;
      end
      if (cmd.mark_dirty) begin
        dirty <= 1'b1;
      end else if (cmd.mark_clean) begin
        dirty <= 1'b0;
      end
      if (accept) begin
        cnt <= '0;
      end else if (do_out) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (do_out) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  assign req.ready            = cmd.take;
  assign rsp.valid            = o_valid;
  assign rsp.action           = o_action;
  assign rsp.target_partition = o_part;
  assign rsp.byte_offset      = o_off;
  assign rsp.chunk_bytes      = o_bytes;
  assign rsp.cache_index      = o_idx;
  assign rsp.last             = o_last;

  always_comb begin
    sts.accept       = accept;
    sts.op           = op;
    sts.reject       = reject_c;
    sts.empty        = (len == '0);
    sts.dirty_loaded = loaded && dirty;
    sts.held         = held;
    sts.last_chunk   = (len == size);
    sts.emit_ok      = (cnt >= RES_LIMIT) || !o_valid || rsp.ready;
  end

  // A result is only written when the output register is free or draining.
  `FSWC_ASSERT_IMP(a_emit_room, do_out, !o_valid || rsp.ready, "result overwritten")
  // A freshly loaded sector is present and clean.
  `FSWC_ASSERT_NXT(a_load_clean, cmd.load, loaded && !dirty, "load left entry dirty")
  // A cache write always lands inside the cached sector.
  `FSWC_ASSERT_IMP(a_wrc_held, cmd.emit && (cmd.act == ACT_WR_CACHE), held_c,
                   "cache write outside entry")
  // The result count never runs past its cap.
  `FSWC_ASSERT_IMP(a_cnt_cap, 1'b1, cnt <= RES_LIMIT, "result count overflow")

endmodule

[rtl/flash_sector_writeback_cache.sv]
`timescale 1ns / 1ps
// Order: after acceptance the sequencer moves to its check state, where a reject, an
// empty request or a flush registers its single result; a read registers its first
// result from the action state after the chunk state, and a write from the cache-write
// state on a hit, the write-back state on a dirty miss or the load state on a clean miss.
// The sequencer steps one action per cycle into a single output register while the
// output is not stalled. Reset empties the entry and result.
// ----------------------------------------------------------------------------
// flash_sector_writeback_cache
// Single-entry write-back sector cache: splits block requests into actions.
// ----------------------------------------------------------------------------
module flash_sector_writeback_cache (
  input logic        clk,
  input logic        rst,
  fswc_req_if.sink   req,
  fswc_rsp_if.source rsp
);
  import fswc_pkg::*;

  fswc_cmd_t cmd;
  fswc_sts_t sts;

  fswc_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  fswc_dp u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

endmodule
